>>> hw/rtl/tctd_pkg.sv
// Package for the topic CRC tag directory: transaction structs, action and
// status codes, sequencer state type and the CRC-16/ARC byte update.
// No dependencies.
`default_nettype none

package tctd_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CRC_W  = 16;

  localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'hA001;

  localparam logic [2:0] ACT_LOOKUP     = 3'd0;
  localparam logic [2:0] ACT_ADD        = 3'd1;
  localparam logic [2:0] ACT_ITER_FIRST = 3'd2;
  localparam logic [2:0] ACT_ITER_NEXT  = 3'd3;
  localparam logic [2:0] ACT_CLEAR      = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] topic_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [5:0]       slot;
    logic [CRC_W-1:0] topic_crc;
  } out_item_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_t;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_ADD,
    OP_ITER_FIRST,
    OP_ITER_NEXT
  } op_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [5:0] slot_out(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+5:0] wide;
    wide = {6'b000000, idx};
    return wide[5:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/topic_crc_tag_directory.sv
// Top level of the topic CRC tag directory: slot table with a CRC memory,
// running CRC and a slot scan sequencer. Depends on tctd_pkg.
`default_nettype none

// Topic bytes are taken one per cycle while no scan runs and the output
// register is not held full; they fold into a running CRC-16/ARC. The
// final byte of a topic, iterate-first and an iterate-next able to advance
// a walk start a scan of the slot table, which reads the CRC memory one
// slot per cycle through its single read port and stops at the first
// matching slot. Clear-all and an iterate-next with no walk in progress
// or at the last slot finish in the next cycle. A new transaction is
// taken once the scan is done and the output register is empty or being
// emptied. No clearing pass runs after reset: reset clears the valid flip-flops.

module topic_crc_tag_directory (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire tctd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output tctd_pkg::out_item_t      out_data
);

  localparam logic [tctd_pkg::SLOT_W-1:0] LAST_IDX =
    tctd_pkg::SLOT_W'(tctd_pkg::SLOTS - 1);

  logic [tctd_pkg::CRC_W-1:0] crc_mem [tctd_pkg::SLOTS];

  tctd_pkg::fsm_t                fsm_r, fsm_nxt;
  tctd_pkg::op_t                 op_r, op_nxt;
  logic [tctd_pkg::SLOTS-1:0]    slot_valid_r, slot_valid_nxt;
  logic [tctd_pkg::CRC_W-1:0]    crc_accum_r, crc_accum_nxt;
  logic [tctd_pkg::CRC_W-1:0]    crc_r, crc_nxt;
  logic                          iter_active_r, iter_active_nxt;
  logic [tctd_pkg::SLOT_W-1:0]   iter_pos_r, iter_pos_nxt;
  logic [tctd_pkg::SLOT_W-1:0]   issue_idx_r, issue_idx_nxt;
  logic                          issue_on_r, issue_on_nxt;
  logic [tctd_pkg::SLOT_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [tctd_pkg::CRC_W-1:0]    rd_data_r;
  logic                          out_valid_r, out_valid_nxt;
  tctd_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                          in_fire;
  logic                          is_topic;
  logic                          start_scan;
  logic                          next_ok;
  logic [tctd_pkg::CRC_W-1:0]    crc_new;
  logic                          valid_at;
  logic                          hit;
  logic                          scan_done;
  logic                          mem_we;

  assign in_ready  = (fsm_r == tctd_pkg::FSM_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_topic = (in_data.action == tctd_pkg::ACT_LOOKUP) ||
                    (in_data.action == tctd_pkg::ACT_ADD);
  assign next_ok  = iter_active_r && (iter_pos_r != LAST_IDX);
  assign start_scan = (is_topic && in_data.last_byte) ||
                      (in_data.action == tctd_pkg::ACT_ITER_FIRST) ||
                      ((in_data.action == tctd_pkg::ACT_ITER_NEXT) && next_ok);
  assign crc_new  = tctd_pkg::crc_byte(crc_accum_r, in_data.topic_byte);
  assign valid_at = slot_valid_r[chk_idx_r];

  always_comb begin
    case (op_r)
      tctd_pkg::OP_LOOKUP: hit = valid_at && (rd_data_r == crc_r);
      tctd_pkg::OP_ADD:    hit = !valid_at;
      default:             hit = valid_at;
    endcase
  end

  assign scan_done = (fsm_r == tctd_pkg::FSM_SCAN) && chk_vld_r &&
                     (hit || (chk_idx_r == LAST_IDX));
  assign mem_we    = scan_done && hit && (op_r == tctd_pkg::OP_ADD);

  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      tctd_pkg::FSM_IDLE: begin
        if (in_fire && start_scan) begin
          fsm_nxt = tctd_pkg::FSM_SCAN;
        end
      end
      tctd_pkg::FSM_SCAN: begin
        if (scan_done) begin
          fsm_nxt = tctd_pkg::FSM_IDLE;
        end
      end
      default: fsm_nxt = tctd_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    op_nxt          = op_r;
    slot_valid_nxt  = slot_valid_r;
    crc_accum_nxt   = crc_accum_r;
    crc_nxt         = crc_r;
    iter_active_nxt = iter_active_r;
    iter_pos_nxt    = iter_pos_r;
    issue_idx_nxt   = issue_idx_r;
    issue_on_nxt    = issue_on_r;
    chk_idx_nxt     = chk_idx_r;
    chk_vld_nxt     = 1'b0;
    out_valid_nxt   = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt    = out_data_r;

    if (in_fire) begin
      issue_on_nxt = start_scan;
      case (in_data.action)
        tctd_pkg::ACT_LOOKUP, tctd_pkg::ACT_ADD: begin
          if (in_data.last_byte) begin
            crc_accum_nxt = '0;
            crc_nxt       = crc_new;
            issue_idx_nxt = '0;
            op_nxt        = (in_data.action == tctd_pkg::ACT_ADD) ?
                            tctd_pkg::OP_ADD : tctd_pkg::OP_LOOKUP;
          end else begin
            crc_accum_nxt = crc_new;
          end
        end
        tctd_pkg::ACT_ITER_FIRST: begin
          issue_idx_nxt = '0;
          op_nxt        = tctd_pkg::OP_ITER_FIRST;
        end
        tctd_pkg::ACT_ITER_NEXT: begin
          op_nxt = tctd_pkg::OP_ITER_NEXT;
          if (next_ok) begin
            issue_idx_nxt = iter_pos_r + 1'b1;
          end else begin
            iter_active_nxt = 1'b0;
            out_valid_nxt   = 1'b1;
            out_data_nxt    = '{status: tctd_pkg::STAT_MISS, slot: '0, topic_crc: '0};
          end
        end
        tctd_pkg::ACT_CLEAR: begin
          slot_valid_nxt = '0;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '{status: tctd_pkg::STAT_OK, slot: '0, topic_crc: '0};
        end
        default: begin
          issue_on_nxt = 1'b0;
        end
      endcase
    end else if (fsm_r == tctd_pkg::FSM_SCAN) begin
      if (issue_on_r) begin
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = issue_idx_r;
        if (issue_idx_r == LAST_IDX) begin
          issue_on_nxt = 1'b0;
        end else begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
      end
      if (scan_done) begin
        issue_on_nxt  = 1'b0;
        chk_vld_nxt   = 1'b0;
        out_valid_nxt = 1'b1;
        case (op_r)
          tctd_pkg::OP_LOOKUP: begin
            if (hit) begin
              out_data_nxt = '{status: tctd_pkg::STAT_OK,
                               slot: tctd_pkg::slot_out(chk_idx_r), topic_crc: crc_r};
            end else begin
              out_data_nxt = '{status: tctd_pkg::STAT_MISS, slot: '0, topic_crc: crc_r};
            end
          end
          tctd_pkg::OP_ADD: begin
            if (hit) begin
              slot_valid_nxt[chk_idx_r] = 1'b1;
              out_data_nxt = '{status: tctd_pkg::STAT_OK,
                               slot: tctd_pkg::slot_out(chk_idx_r), topic_crc: crc_r};
            end else begin
              out_data_nxt = '{status: tctd_pkg::STAT_FULL, slot: '0, topic_crc: crc_r};
            end
          end
          default: begin
            if (hit) begin
              iter_active_nxt = 1'b1;
              iter_pos_nxt    = chk_idx_r;
              out_data_nxt    = '{status: tctd_pkg::STAT_OK,
                                  slot: tctd_pkg::slot_out(chk_idx_r),
                                  topic_crc: rd_data_r};
            end else begin
              if (op_r == tctd_pkg::OP_ITER_NEXT) begin
                iter_active_nxt = 1'b0;
              end
              out_data_nxt = '{status: tctd_pkg::STAT_MISS, slot: '0, topic_crc: '0};
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r         <= tctd_pkg::FSM_IDLE;
      slot_valid_r  <= '0;
      crc_accum_r   <= '0;
      iter_active_r <= 1'b0;
      iter_pos_r    <= '0;
      issue_on_r    <= 1'b0;
      chk_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      fsm_r         <= fsm_nxt;
      slot_valid_r  <= slot_valid_nxt;
      crc_accum_r   <= crc_accum_nxt;
      iter_active_r <= iter_active_nxt;
      iter_pos_r    <= iter_pos_nxt;
      issue_on_r    <= issue_on_nxt;
      chk_vld_r     <= chk_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    crc_r       <= crc_nxt;
    issue_idx_r <= issue_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      crc_mem[chk_idx_r] <= crc_r;
    end
    if ((fsm_r == tctd_pkg::FSM_SCAN) && issue_on_r) begin
      rd_data_r <= crc_mem[issue_idx_r];
    end
  end

endmodule

`default_nettype wire
